[design/chm_pkg.sv]
// Shared constants, request codes and the prime table of the chained hash map engine.
// No dependencies; the top level and chm_hash import this package.
`default_nettype none
package chm_pkg;

  localparam int PRIME_W = 20;
  localparam int LVL_W = 4;
  localparam int KEY_W = 32;

  localparam logic [2:0] REQ_SET   = 3'd0;
  localparam logic [2:0] REQ_GET   = 3'd1;
  localparam logic [2:0] REQ_TAKE  = 3'd2;
  localparam logic [2:0] REQ_DEL   = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  localparam logic [31:0] MIX_MULT = 32'h27d4eb2d;
  localparam logic [31:0] MIX_SEED = 32'd61;

  // Prime bucket count of each size level.
  function automatic logic [PRIME_W-1:0] prime_at(input logic [LVL_W-1:0] lvl);
    logic [PRIME_W-1:0] p;
    case (lvl)
      4'd0:    p = 20'd13;
      4'd1:    p = 20'd31;
      4'd2:    p = 20'd61;
      4'd3:    p = 20'd127;
      4'd4:    p = 20'd251;
      4'd5:    p = 20'd509;
      4'd6:    p = 20'd1021;
      4'd7:    p = 20'd2039;
      4'd8:    p = 20'd4093;
      4'd9:    p = 20'd8191;
      4'd10:   p = 20'd16381;
      4'd11:   p = 20'd32749;
      4'd12:   p = 20'd65521;
      4'd13:   p = 20'd131071;
      4'd14:   p = 20'd262139;
      default: p = 20'd524287;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

[design/chained_hash_map_engine_unit.sv]
// Top level of the chained hash map engine: request sequencer around the table memories.
// Depends on chm_pkg, chm_ram and chm_hash.
`default_nettype none
// One request is taken at a time. A get, set, take or delete first hashes the key in
// chm_hash (a multiply and a bit-serial 32-step modulo), then visits chain nodes, each
// node being one read of the node memories.
// A clear sweeps the bucket head memory, one entry a cycle over the current bucket count.
// After reset the bucket heads are cleared before the first request is accepted.
// A resize rehash walks every old bucket and node, clears the new bucket range, and then
// reinserts each entry, all through memories with one write port and one registered
// read port.
// A result waits in an output register while the next request is already accepted.
module chained_hash_map_engine_unit
  import chm_pkg::*;
#(
  parameter int POOL_ENTRIES  = 1024,
  parameter int BUCKET_LEVELS = 8,
  parameter int VALUE_WIDTH   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // key[31:0], value[63:32]
  input  wire logic [2:0]  s_tuser,   // req_type[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // found[0], was_new[1], value_out[33:2], status[34], entry_count[45:35],
  // bucket_count[56:46], zero[63:57]
  output logic      [63:0] m_tdata
);

  localparam int MAX_B = int'(prime_at(LVL_W'(BUCKET_LEVELS - 1)));
  localparam int BW    = $clog2(MAX_B);
  localparam int DIV_W = $clog2(MAX_B + 1);
  localparam int NW    = $clog2(POOL_ENTRIES);
  localparam int CW    = $clog2(POOL_ENTRIES + 1);
  localparam int CMP_W = PRIME_W + 4;
  localparam logic [CW-1:0] NIL  = CW'(POOL_ENTRIES);
  localparam logic [CW-1:0] FULL = CW'(POOL_ENTRIES);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_HASH, S_HEAD, S_NODE, S_MISS, S_POP, S_INS, S_CHECK,
    R_BREAD, R_BHEAD, R_WALK, R_LREAD, R_LKEY, R_HSTART, R_HWAIT, R_LINS, S_RESP
  } state_t;

  typedef enum logic [1:0] {RET_IDLE, RET_RESP, RET_REH} ret_t;

  state_t                 state;
  ret_t                   ret;
  logic [2:0]             kind;
  logic [KEY_W-1:0]       rkey;
  logic [VALUE_WIDTH-1:0] rval;
  logic [LVL_W-1:0]       level, newlvl;
  logic [CW-1:0]          count, hw, ftop, lcnt, rj;
  logic [BW-1:0]          bkt, cj, ri, rh;
  logic [CW-1:0]          cur, prev, headv;
  logic [NW-1:0]          newn, rn;
  logic                   rfound, rnew, rstat;
  logic [VALUE_WIDTH-1:0] rvout;

  logic [PRIME_W-1:0] bcur;
  logic [BW-1:0]      blast;
  logic [CW-1:0]      ftop_m1;
  logic               accept;

  logic                   heads_we, keys_we, vals_we, links_we, fs_we, list_we;
  logic [BW-1:0]          heads_wa, heads_ra;
  logic [CW-1:0]          heads_wd, heads_rd, links_wd, links_rd;
  logic [NW-1:0]          keys_wa, vals_wa, links_wa, fs_wa, list_wa, node_ra, list_ra;
  logic [NW-1:0]          fs_wd, list_wd, fs_rd, list_rd;
  logic [KEY_W-1:0]       keys_rd;
  logic [VALUE_WIDTH-1:0] vals_wd, vals_rd;

  logic               h_start, h_done;
  logic [KEY_W-1:0]   h_key;
  logic [DIV_W-1:0]   h_rem;

  assign bcur     = prime_at(level);
  assign blast    = BW'(bcur - PRIME_W'(1));
  assign ftop_m1  = ftop - CW'(1);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign h_key    = (state == R_HSTART) ? keys_rd : s_tdata[31:0];
  assign h_start  = (state == R_HSTART) || (accept && s_tuser <= REQ_DEL);

  always_comb begin
    heads_we = 1'b0;
    heads_wa = cj;
    heads_wd = NIL;
    heads_ra = ri;
    keys_we  = 1'b0;
    keys_wa  = newn;
    vals_we  = 1'b0;
    vals_wa  = newn;
    vals_wd  = rval;
    links_we = 1'b0;
    links_wa = newn;
    links_wd = headv;
    node_ra  = heads_rd[NW-1:0];
    fs_we    = 1'b0;
    fs_wa    = ftop[NW-1:0];
    fs_wd    = cur[NW-1:0];
    list_we  = 1'b0;
    list_wa  = lcnt[NW-1:0];
    list_wd  = heads_rd[NW-1:0];
    list_ra  = rj[NW-1:0];
    case (state)
      S_CLR: heads_we = 1'b1;
      S_HASH: heads_ra = BW'(h_rem);
      S_NODE: begin
        node_ra = links_rd[NW-1:0];
        if (keys_rd == rkey) begin
          if (kind == REQ_SET) begin
            vals_we = 1'b1;
            vals_wa = cur[NW-1:0];
          end else if (kind != REQ_GET) begin
            fs_we = 1'b1;
            if (prev != NIL) begin
              links_we = 1'b1;
              links_wa = prev[NW-1:0];
              links_wd = links_rd;
            end else begin
              heads_we = 1'b1;
              heads_wa = bkt;
              heads_wd = links_rd;
            end
          end
        end
      end
      S_INS: begin
        keys_we  = 1'b1;
        vals_we  = 1'b1;
        links_we = 1'b1;
        heads_we = 1'b1;
        heads_wa = bkt;
        heads_wd = CW'(newn);
      end
      R_BHEAD: list_we = (heads_rd != NIL);
      R_WALK: begin
        node_ra = links_rd[NW-1:0];
        list_we = (links_rd != NIL);
        list_wd = links_rd[NW-1:0];
      end
      R_LKEY: node_ra = list_rd;
      R_HWAIT: heads_ra = BW'(h_rem);
      R_LINS: begin
        links_we = 1'b1;
        links_wa = rn;
        links_wd = heads_rd;
        heads_we = 1'b1;
        heads_wa = rh;
        heads_wd = CW'(rn);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      ret      <= RET_IDLE;
      cj       <= '0;
      level    <= '0;
      count    <= '0;
      hw       <= '0;
      ftop     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_RESP && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          cj <= cj + BW'(1);
          if (cj == blast) begin
            case (ret)
              RET_IDLE: state <= S_IDLE;
              RET_RESP: state <= S_RESP;
              default: begin
                rj    <= '0;
                state <= (lcnt == '0) ? S_RESP : R_LREAD;
              end
            endcase
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind   <= s_tuser;
            rkey   <= s_tdata[31:0];
            rval   <= VALUE_WIDTH'(s_tdata[63:32]);
            rfound <= 1'b0;
            rnew   <= 1'b0;
            rstat  <= 1'b0;
            rvout  <= '0;
            if (s_tuser == REQ_CLEAR) begin
              count <= '0;
              hw    <= '0;
              ftop  <= '0;
              cj    <= '0;
              ret   <= RET_RESP;
              state <= S_CLR;
            end else if (s_tuser > REQ_CLEAR) begin
              state <= S_RESP;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (h_done) begin
            bkt   <= BW'(h_rem);
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          headv <= heads_rd;
          cur   <= heads_rd;
          prev  <= NIL;
          state <= (heads_rd == NIL) ? S_MISS : S_NODE;
        end
        S_NODE: begin
          if (keys_rd == rkey) begin
            rfound <= 1'b1;
            if (kind == REQ_GET || kind == REQ_TAKE) begin
              rvout <= vals_rd;
            end
            if (kind == REQ_TAKE || kind == REQ_DEL) begin
              ftop  <= ftop + CW'(1);
              count <= count - CW'(1);
              state <= S_CHECK;
            end else begin
              state <= S_RESP;
            end
          end else if (links_rd == NIL) begin
            state <= S_MISS;
          end else begin
            prev <= cur;
            cur  <= links_rd;
          end
        end
        S_MISS: begin
          if (kind != REQ_SET) begin
            state <= S_RESP;
          end else if (count == FULL) begin
            rstat <= 1'b1;
            state <= S_RESP;
          end else if (ftop != '0) begin
            ftop  <= ftop_m1;
            state <= S_POP;
          end else begin
            newn  <= hw[NW-1:0];
            hw    <= hw + CW'(1);
            state <= S_INS;
          end
        end
        S_POP: begin
          newn  <= fs_rd;
          state <= S_INS;
        end
        S_INS: begin
          count <= count + CW'(1);
          rnew  <= 1'b1;
          state <= S_CHECK;
        end
        S_CHECK: begin
          ri   <= '0;
          lcnt <= '0;
          if (level != '0 && (CMP_W'(count) << 2) <= CMP_W'(bcur)) begin
            newlvl <= level - LVL_W'(1);
            state  <= R_BREAD;
          end else if ((5'(level) + 5'd1) < 5'(BUCKET_LEVELS)
                       && CMP_W'(count) >= (CMP_W'(bcur) << 1)) begin
            newlvl <= level + LVL_W'(1);
            state  <= R_BREAD;
          end else begin
            state <= S_RESP;
          end
        end
        R_BREAD: state <= R_BHEAD;
        R_BHEAD, R_WALK: begin
          if ((state == R_BHEAD ? heads_rd : links_rd) != NIL) begin
            lcnt  <= lcnt + CW'(1);
            state <= R_WALK;
          end else if (ri == blast) begin
            level <= newlvl;
            cj    <= '0;
            ret   <= RET_REH;
            state <= S_CLR;
          end else begin
            ri    <= ri + BW'(1);
            state <= R_BREAD;
          end
        end
        R_LREAD: state <= R_LKEY;
        R_LKEY: begin
          rn    <= list_rd;
          state <= R_HSTART;
        end
        R_HSTART: state <= R_HWAIT;
        R_HWAIT: begin
          if (h_done) begin
            rh    <= BW'(h_rem);
            state <= R_LINS;
          end
        end
        R_LINS: begin
          rj <= rj + CW'(1);
          state <= (rj + CW'(1) == lcnt) ? S_RESP : R_LREAD;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {7'd0, 11'(bcur), 11'(count), rstat, 32'(rvout), rnew, rfound};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  chm_hash #(.DIV_W(DIV_W)) u_hash (
    .clk(clk), .rst(rst), .start(h_start), .key(h_key),
    .divisor(DIV_W'(bcur)), .done(h_done), .rem(h_rem)
  );

  chm_ram #(.WIDTH(CW), .DEPTH(MAX_B)) u_heads (
    .clk(clk), .we(heads_we), .waddr(heads_wa), .wdata(heads_wd),
    .raddr(heads_ra), .rdata(heads_rd)
  );

  chm_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES)) u_keys (
    .clk(clk), .we(keys_we), .waddr(keys_wa), .wdata(rkey),
    .raddr(node_ra), .rdata(keys_rd)
  );

  chm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_ENTRIES)) u_vals (
    .clk(clk), .we(vals_we), .waddr(vals_wa), .wdata(vals_wd),
    .raddr(node_ra), .rdata(vals_rd)
  );

  chm_ram #(.WIDTH(CW), .DEPTH(POOL_ENTRIES)) u_links (
    .clk(clk), .we(links_we), .waddr(links_wa), .wdata(links_wd),
    .raddr(node_ra), .rdata(links_rd)
  );

  // Stack of released nodes; fresh nodes come from the high-water count hw.
  chm_ram #(.WIDTH(NW), .DEPTH(POOL_ENTRIES)) u_free (
    .clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
    .raddr(ftop_m1[NW-1:0]), .rdata(fs_rd)
  );

  // Nodes gathered during a rehash walk, reinserted afterward.
  chm_ram #(.WIDTH(NW), .DEPTH(POOL_ENTRIES)) u_list (
    .clk(clk), .we(list_we), .waddr(list_wa), .wdata(list_wd),
    .raddr(list_ra), .rdata(list_rd)
  );

endmodule
`default_nettype wire

[design/chm_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none
module chm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/chm_hash.sv]
// Multi-cycle key hash: 32-bit integer mix, then a bit-serial modulo by a prime.
// Depends on chm_pkg for the mix constants.
`default_nettype none
module chm_hash
  import chm_pkg::*;
#(
  parameter int DIV_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [KEY_W-1:0] key,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic      [DIV_W-1:0] rem
);

  typedef enum logic [1:0] {H_IDLE, H_MUL, H_FIN, H_DIV} hstate_t;

  hstate_t          state;
  logic [31:0]      x;
  logic [31:0]      q;
  logic [DIV_W-1:0] d;
  logic [4:0]       cnt;
  logic [31:0]      mix_a, mix_b, mix_c;
  logic [DIV_W:0]   trial;

  always_comb begin
    mix_a = (key ^ MIX_SEED) ^ (key >> 16);
    mix_b = mix_a + (mix_a << 3);
    mix_c = mix_b ^ (mix_b >> 4);
    trial = {rem, q[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        H_IDLE: begin
          if (start) begin
            x     <= mix_c;
            d     <= divisor;
            state <= H_MUL;
          end
        end
        H_MUL: begin
          x     <= x * MIX_MULT;
          state <= H_FIN;
        end
        H_FIN: begin
          q     <= x ^ (x >> 15);
          rem   <= '0;
          cnt   <= '0;
          state <= H_DIV;
        end
        H_DIV: begin
          // Restoring remainder, one dividend bit per cycle, MSB first.
          if (trial >= {1'b0, d}) begin
            rem <= DIV_W'(trial - {1'b0, d});
          end else begin
            rem <= trial[DIV_W-1:0];
          end
          q   <= q << 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
